### rtl/lpfe_pkg.sv
// lpfe_pkg: types, codes and constants of the led pixel fade engine
// no dependencies; imported by led_pixel_fade_engine_core, lpfe_result_checker and tb_top
package lpfe_pkg;

  localparam int MAX_PIXELS = 64;
  localparam int IDX_W      = $clog2(MAX_PIXELS);
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam logic [7:0] FULL_BYTE = 8'd255;

  // request kinds
  typedef enum logic [1:0] {
    KIND_FADE = 2'd0,
    KIND_SET  = 2'd1,
    KIND_FILL = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // one pixel entry of the state memory
  typedef struct packed {
    logic [2:0] rise;
    rgb_t       tgt;
    rgb_t       cur;
  } pixel_t;

  // one tick step of a single channel
  function automatic logic [7:0] step_byte(input logic [7:0] cur, input logic [7:0] tgt,
                                           input logic rise);
    logic [7:0] res;
    res = cur;
    if (cur != tgt) begin
      if (rise && (cur != FULL_BYTE)) begin
        res = cur + 8'd1;
      end else if (cur != 8'd0) begin
        res = cur - 8'd1;
      end
    end
    return res;
  endfunction

endpackage

### rtl/led_pixel_fade_engine_core.sv
// led_pixel_fade_engine_core: per-pixel fade engine built around one state memory
// depends on lpfe_pkg (types, kind codes, step function)
//
// Usage:
//   s_* carries requests: s_tuser is the kind (fade, set, fill, tick), s_tdata
//   holds pixel index and colour. m_* carries results: one per fade, set or
//   fill, one per pixel in use for a tick, the final one marked by m_tlast.
//   pixel_count_we/pixel_count_wdata set the number of pixels in use while idle.
// Timing:
//   one request at a time. A fill or tick sweeps the pixels in use through one
//   read port, one pixel a cycle unless a result is held; a fade or set reads
//   only its own pixel. Each pixel is read, then modified and written back; a
//   stall can come between. The first result is registered in the output
//   register after the read. The next request is taken once the sweep has
//   drained. A tick streams its results one per cycle while m_tready is high.
// Reset:
//   rst clears the pixel valid bits, so every pixel reads as all zero (current,
//   target and rising bits), and sets the pixel count to 64. No sweep needed.
// Stall:
//   a held result stays in the output register; the sweep pauses with the
//   pending read data held and resumes when the result is taken.
module led_pixel_fade_engine_core (
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [31:0]              s_tdata,   // pixel_index[5:0], red, green, blue, zero pad
  input  logic [1:0]               s_tuser,   // kind[1:0]
  // result channel
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [31:0]              m_tdata,   // out_index[5:0], out_red, out_green, out_blue, pad
  output logic [1:0]               m_tuser,   // status, all_complete
  output logic                     m_tlast,
  // configuration
  input  logic                     pixel_count_we,
  input  logic [lpfe_pkg::CNT_W-1:0] pixel_count_wdata
);
  import lpfe_pkg::*;

  // configuration and request registers
  logic [CNT_W-1:0] pixel_count;
  kind_t            op_kind;
  rgb_t             op_rgb;
  logic             op_err;
  logic             op_single;
  logic             all_acc;

  // sequencer
  state_t           state, state_next;
  logic [IDX_W-1:0] rd_ptr;
  logic             ptr_last;
  logic             issue;
  logic             adv;
  logic             accept;

  // read stage
  pixel_t           mem [MAX_PIXELS];
  logic [MAX_PIXELS-1:0] vld;
  pixel_t           rdata;
  logic             rd_valid;
  logic             rd_vld;
  logic             rd_last;
  logic [IDX_W-1:0] rd_addr;

  // modify stage
  logic [IDX_W-1:0] n_last;
  pixel_t           cur_e;
  pixel_t           new_e;
  logic             eq;
  logic             emit;
  logic             wr_en;

  // index of the last pixel in use
  always_comb begin
    if (pixel_count == '0) begin
      n_last = '0;
    end else if (pixel_count >= CNT_W'(MAX_PIXELS)) begin
      n_last = IDX_W'(MAX_PIXELS - 1);
    end else begin
      n_last = IDX_W'(pixel_count - CNT_W'(1));
    end
  end

  // handshake and pipeline control
  assign accept   = s_tvalid && s_tready;
  assign ptr_last = op_single || (rd_ptr == n_last);
  assign emit     = (op_kind == KIND_TICK) || rd_last;
  assign adv      = rd_valid && (!emit || !m_tvalid || m_tready);
  assign wr_en    = adv && !op_err;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (issue && ptr_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_ISSUE: issue = !rd_valid || adv;
      ST_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pixel count register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= CNT_W'(MAX_PIXELS);
    end else if (pixel_count_we) begin
      pixel_count <= pixel_count_wdata;
    end
  end

  // latch the request and walk the read pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind   <= kind_t'(s_tuser);
      op_rgb    <= rgb_t'(s_tdata[IDX_W +: 24]);
      op_single <= (s_tuser == KIND_FADE) || (s_tuser == KIND_SET);
      op_err    <= ((s_tuser == KIND_FADE) || (s_tuser == KIND_SET)) &&
                   (s_tdata[IDX_W-1:0] > n_last);
      rd_ptr    <= ((s_tuser == KIND_FADE) || (s_tuser == KIND_SET)) ?
                   s_tdata[IDX_W-1:0] : '0;
    end else if (issue) begin
      rd_ptr <= rd_ptr + IDX_W'(1);
    end
  end

  // read stage bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (issue) begin
      rd_valid <= 1'b1;
    end else if (adv) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr <= rd_ptr;
      rd_last <= ptr_last;
      rd_vld  <= vld[rd_ptr];
    end
  end

  // pixel memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_addr] <= new_e;
    end
    if (issue) begin
      rdata <= mem[rd_ptr];
    end
  end

  // valid bits: unwritten pixels read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[rd_addr] <= 1'b1;
    end
  end

  // modify the entry held in the read stage
  always_comb begin
    cur_e = rd_vld ? rdata : '0;
    eq    = (cur_e.cur == cur_e.tgt);
    new_e = cur_e;
    case (op_kind)
      KIND_FADE: begin
        new_e.tgt     = op_rgb;
        new_e.rise[0] = cur_e.cur.red   < op_rgb.red;
        new_e.rise[1] = cur_e.cur.green < op_rgb.green;
        new_e.rise[2] = cur_e.cur.blue  < op_rgb.blue;
      end
      KIND_SET, KIND_FILL: begin
        new_e.cur = op_rgb;
        new_e.tgt = op_rgb;
      end
      KIND_TICK: begin
        new_e.cur.red   = step_byte(cur_e.cur.red,   cur_e.tgt.red,   cur_e.rise[0]);
        new_e.cur.green = step_byte(cur_e.cur.green, cur_e.tgt.green, cur_e.rise[1]);
        new_e.cur.blue  = step_byte(cur_e.cur.blue,  cur_e.tgt.blue,  cur_e.rise[2]);
      end
      default: new_e = cur_e;
    endcase
  end

  // running all-complete test over the tick sweep
  always_ff @(posedge clk) begin
    if (accept) begin
      all_acc <= 1'b1;
    end else if (adv) begin
      all_acc <= all_acc && eq;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      m_tlast <= rd_last;
      if (op_kind == KIND_TICK) begin
        m_tdata <= {2'b00, new_e.cur, rd_addr};
        m_tuser <= {rd_last && all_acc && eq, 1'b0};
      end else begin
        m_tdata <= '0;
        m_tuser <= {1'b0, op_err};
      end
    end
  end

  // no read in flight while requests are taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !rd_valid)
    else $error("read in flight while idle");

  // a stalled read stage holds its address
  a_hold_addr: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && !adv) |=> (rd_valid && $stable(rd_addr)))
    else $error("stalled read stage lost its pixel");

  // every issued read reaches the modify stage
  a_issue_valid: assert property (@(posedge clk) disable iff (rst)
    issue |=> rd_valid)
    else $error("issued read not tracked");

  // all-complete appears only on a final result
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("all_complete on a non-final result");

endmodule

### tb/lpfe_result_checker.sv
// lpfe_result_checker: watches the request, result and config ports of the fade engine,
// predicts every result from its own pixel store and compares them in order
// depends on lpfe_pkg (kind codes, MAX_PIXELS, CNT_W)
module lpfe_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [31:0]                s_tdata,
  input  logic [1:0]                 s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [31:0]                m_tdata,
  input  logic [1:0]                 m_tuser,
  input  logic                       m_tlast,
  input  logic                       pixel_count_we,
  input  logic [lpfe_pkg::CNT_W-1:0] pixel_count_wdata,
  output int                         fail_count,
  output int                         pending,
  output int                         requests_seen,
  output int                         results_seen
);
  import lpfe_pkg::*;

  // colour vectors hold red in [7:0], green in [15:8], blue in [23:16]
  typedef struct packed {
    logic        status;
    logic [5:0]  index;
    logic [23:0] colour;
    logic        last;
    logic        done;
  } pixel_result_t;

  pixel_result_t    expected_pixel_results[$];
  logic [23:0]      cur_col [MAX_PIXELS];
  logic [23:0]      tgt_col [MAX_PIXELS];
  logic [2:0]       rise_bits [MAX_PIXELS];
  logic [CNT_W-1:0] count_reg;
  logic             complete_flag;

  // pixel count as the engine uses it: zero means one, above the maximum means the maximum
  function automatic int pixels_in_use(input logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_PIXELS) return MAX_PIXELS;
    return int'(c);
  endfunction

  function automatic void report_field(input string name, input int want, input int got);
    fail_count++;
    $display("%0t: result %0d field %s: expected %0h, got %0h",
             $time, results_seen, name, want, got);
  endfunction

  // update the pixel store for one request and queue the results it causes
  function automatic void apply_request(input kind_t k, input logic [5:0] idx,
                                        input logic [23:0] rgb);
    int            n;
    logic          all_eq;
    logic [7:0]    cb;
    logic [7:0]    tb;
    logic [2:0]    rise;
    pixel_result_t res;
    n = pixels_in_use(count_reg);
    res = '0;
    res.last = 1'b1;
    case (k)
      KIND_TICK: begin
        // completion is judged before any channel moves
        all_eq = 1'b1;
        for (int p = 0; p < n; p++) begin
          if (cur_col[p] != tgt_col[p]) all_eq = 1'b0;
        end
        complete_flag = all_eq;
        for (int p = 0; p < n; p++) begin
          for (int c = 0; c < 3; c++) begin
            cb = cur_col[p][c*8 +: 8];
            tb = tgt_col[p][c*8 +: 8];
            if (cb != tb) begin
              if (rise_bits[p][c] && cb != 8'hFF) cb = cb + 8'd1;
              else if (cb != 8'h00) cb = cb - 8'd1;
            end
            cur_col[p][c*8 +: 8] = cb;
          end
          res.index  = 6'(p);
          res.colour = cur_col[p];
          res.last   = (p == n - 1);
          res.done   = (p == n - 1) && all_eq;
          expected_pixel_results.push_back(res);
        end
      end
      KIND_FILL: begin
        for (int p = 0; p < n; p++) begin
          cur_col[p] = rgb;
          tgt_col[p] = rgb;
        end
        expected_pixel_results.push_back(res);
      end
      default: begin
        if (int'(idx) >= n) begin
          res.status = 1'b1;
        end else begin
          tgt_col[idx] = rgb;
          if (k == KIND_SET) begin
            cur_col[idx] = rgb;
          end else begin
            rise = 3'b000;
            for (int c = 0; c < 3; c++) begin
              if (cur_col[idx][c*8 +: 8] < rgb[c*8 +: 8]) rise[c] = 1'b1;
            end
            rise_bits[idx] = rise;
          end
        end
        expected_pixel_results.push_back(res);
      end
    endcase
  endfunction

  // track config writes, predict on each request, compare each result
  always @(posedge clk) begin
    pixel_result_t got;
    pixel_result_t want;
    if (rst) begin
      for (int p = 0; p < MAX_PIXELS; p++) begin
        cur_col[p]   = '0;
        tgt_col[p]   = '0;
        rise_bits[p] = '0;
      end
      count_reg     = CNT_W'(MAX_PIXELS);
      complete_flag = 1'b0;
      expected_pixel_results.delete();
      fail_count      = 0;
      requests_seen   = 0;
      results_seen    = 0;
    end else begin
      if (pixel_count_we) count_reg = pixel_count_wdata;
      if (s_tvalid && s_tready) begin
        apply_request(kind_t'(s_tuser), s_tdata[5:0], s_tdata[29:6]);
        requests_seen++;
      end
      if (m_tvalid && m_tready) begin
        got.status = m_tuser[0];
        got.done   = m_tuser[1];
        got.index  = m_tdata[5:0];
        got.colour = m_tdata[29:6];
        got.last   = m_tlast;
        if (expected_pixel_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected: expected none, got index %0d rgb %06h",
                   $time, got.index, got.colour);
        end else begin
          want = expected_pixel_results.pop_front();
          if (got.status !== want.status)
            report_field("status", int'(want.status), int'(got.status));
          if (got.index !== want.index)
            report_field("out_index", int'(want.index), int'(got.index));
          if (got.colour[7:0] !== want.colour[7:0])
            report_field("out_red", int'(want.colour[7:0]), int'(got.colour[7:0]));
          if (got.colour[15:8] !== want.colour[15:8])
            report_field("out_green", int'(want.colour[15:8]), int'(got.colour[15:8]));
          if (got.colour[23:16] !== want.colour[23:16])
            report_field("out_blue", int'(want.colour[23:16]), int'(got.colour[23:16]));
          if (got.last !== want.last)
            report_field("last", int'(want.last), int'(got.last));
          if (got.done !== want.done)
            report_field("all_complete", int'(want.done), int'(got.done));
        end
        results_seen++;
      end
    end
    pending = expected_pixel_results.size();
  end

endmodule

### tb/tb_top.sv
// tb_top: clock, reset and stimulus for led_pixel_fade_engine_core, plus the final verdict
// depends on lpfe_pkg, led_pixel_fade_engine_core and lpfe_result_checker
module tb_top;
  import lpfe_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 8;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;
  logic [1:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [31:0]      m_tdata;
  logic [1:0]       m_tuser;
  logic             m_tlast;
  logic             pixel_count_we = 1'b0;
  logic [CNT_W-1:0] pixel_count_wdata = '0;

  int fail_count;
  int pending;
  int requests_seen;
  int results_seen;
  int settings_used = 0;
  bit idle_on = 1'b0;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int phase_counts [8] = '{64, 1, 0, 5, 127, 100, 33, 64};

  led_pixel_fade_engine_core dut (
    .clk               (clk),
    .rst               (rst),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .s_tuser           (s_tuser),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tuser           (m_tuser),
    .m_tlast           (m_tlast),
    .pixel_count_we    (pixel_count_we),
    .pixel_count_wdata (pixel_count_wdata)
  );

  lpfe_result_checker result_check (
    .clk               (clk),
    .rst               (rst),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .s_tuser           (s_tuser),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tuser           (m_tuser),
    .m_tlast           (m_tlast),
    .pixel_count_we    (pixel_count_we),
    .pixel_count_wdata (pixel_count_wdata),
    .fail_count        (fail_count),
    .pending           (pending),
    .requests_seen     (requests_seen),
    .results_seen      (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result receiver: random stalls, or one long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < 10);
    end
  end

  // watchdog on cycles with no request and no result taken
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results outstanding", quiet_cycles, pending);
      $display("led_pixel_fade_engine_core: mismatch");
      $finish;
    end
  end

  function automatic int pixels_for(input int v);
    if (v == 0) return 1;
    if (v > MAX_PIXELS) return MAX_PIXELS;
    return v;
  endfunction

  // colour bytes lean toward the ends of the range so fades saturate and finish
  function automatic logic [23:0] pick_colour();
    logic [23:0] c;
    int          v;
    for (int i = 0; i < 3; i++) begin
      v = $urandom_range(4);
      if ($urandom_range(99) < 40) c[i*8 +: 8] = (v < 3) ? 8'(v) : 8'(251 + v);
      else c[i*8 +: 8] = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // offer one request and hold it until taken; rgb is {blue, green, red}
  task automatic send_req(input kind_t k, input logic [5:0] idx, input logic [23:0] rgb);
    while (idle_on && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {2'b00, rgb, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering until every queued result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_count(input int v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    pixel_count_we    <= 1'b1;
    pixel_count_wdata <= CNT_W'(v);
    @(posedge clk);
    pixel_count_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random(input int n_items, input int n_pix);
    int    sel;
    kind_t k;
    logic [5:0] idx;
    repeat (n_items) begin
      sel = $urandom_range(99);
      if (sel < 35) k = KIND_FADE;
      else if (sel < 55) k = KIND_SET;
      else if (sel < 63) k = KIND_FILL;
      else k = KIND_TICK;
      if ($urandom_range(99) < 15) idx = 6'($urandom_range(63));
      else idx = 6'($urandom_range(n_pix - 1));
      send_req(k, idx, pick_colour());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fresh store, set, fades in each direction, fill, completion
    send_req(KIND_TICK, 6'd0, 24'h000000);
    send_req(KIND_SET, 6'd0, 24'hFFFFFF);
    send_req(KIND_SET, 6'd63, {8'hFE, 8'h01, 8'h80});
    send_req(KIND_FADE, 6'd0, {8'hFF, 8'h80, 8'h00});
    send_req(KIND_FADE, 6'd5, {8'h01, 8'h00, 8'hFF});
    send_req(KIND_FADE, 6'd63, {8'hFE, 8'h01, 8'h80});
    send_req(KIND_TICK, 6'd0, 24'h000000);
    send_req(KIND_TICK, 6'd63, 24'hFFFFFF);
    send_req(KIND_FILL, 6'd0, {8'h0F, 8'hAA, 8'h55});
    send_req(KIND_TICK, 6'd0, 24'h000000);
    send_req(KIND_FADE, 6'd7, {8'h0F, 8'hAA, 8'h56});
    send_req(KIND_SET, 6'd4, {8'hFE, 8'h00, 8'h00});
    send_req(KIND_FADE, 6'd4, {8'hFF, 8'h01, 8'h00});
    send_req(KIND_TICK, 6'd0, 24'h000000);
    send_req(KIND_TICK, 6'd0, 24'h000000);

    // directed: small count, out-of-range index, fill limited to pixels in use
    write_count(3);
    send_req(KIND_FADE, 6'd3, 24'h123456);
    send_req(KIND_SET, 6'd63, 24'hFFFFFF);
    send_req(KIND_SET, 6'd2, 24'h000000);
    send_req(KIND_FADE, 6'd2, 24'hFFFFFF);
    send_req(KIND_FILL, 6'd0, 24'h123456);
    send_req(KIND_TICK, 6'd0, 24'h000000);

    // pixels past the old count keep their state once the count grows back
    write_count(64);
    send_req(KIND_TICK, 6'd0, 24'h000000);

    // random phases, one per pixel-count setting
    foreach (phase_counts[i]) begin
      write_count(phase_counts[i]);
      idle_on = (i != 0);
      if (phase_counts[i] == 100) hold_request = 1'b1;
      send_random(10, pixels_for(phase_counts[i]));
      if (i == 6) wait_drained();
      send_random(7, pixels_for(phase_counts[i]));
    end

    // drain, then let the engine settle
    wait_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d requests and %0d results over %0d pixel-count settings",
             requests_seen, results_seen, settings_used);
    $display("settings included zero and above-maximum counts, out-of-range indexes and stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("led_pixel_fade_engine_core: match");
    end else begin
      $display("led_pixel_fade_engine_core: mismatch");
    end
    $finish;
  end

endmodule
